// ----- design/cpt_pkg.sv -----
// Package for the cursor particle trail: constants, types and arithmetic helpers.
// No dependencies.
package cpt_pkg;
	localparam int SLOTS_DEF = 32;
	localparam logic [31:0] SEED_MASK = 32'hA5A5C3C3;
	localparam logic [31:0] HASH_MUL1 = 32'd2654435761;
	localparam logic [31:0] HASH_MUL2 = 32'h045d9f3b;
	localparam logic [31:0] AB_BIG = 32'd123;
	localparam logic [31:0] AB_SMALL = 32'd51;
	localparam logic signed [31:0] K_ONE = 32'sd65536;
	localparam logic signed [31:0] K_HALF = 32'sd32768;
	localparam logic signed [31:0] K_DAMP = 32'sd62914;
	localparam logic signed [31:0] K_GRAV = 32'sd3276;
	localparam logic signed [31:0] K_VSCALE = 32'sd3276;
	localparam logic signed [31:0] K_LIFEDEC = 32'sd98304;
	localparam logic signed [31:0] K_OFF_Y = 32'sd72089;
	localparam logic signed [31:0] K_OFF_VX = 32'sd58982;
	localparam logic signed [31:0] K_OFF_VY = 32'sd78643;
	localparam logic signed [31:0] K_TEN = 32'sd655360;
	localparam logic signed [31:0] K_TWO = 32'sd131072;
	localparam logic signed [31:0] K_HALFK = 32'sd32768;
	localparam logic signed [31:0] K_FOUR = 32'sd262144;
	localparam logic signed [31:0] K_SIXTY = 32'sd3932160;
	localparam logic signed [31:0] K_HUE0 = 32'sd15728640;
	localparam logic signed [31:0] K_THRESH = 32'sd131072;
	localparam logic signed [31:0] K_PREV0 = -32'sd6553600;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ISSUE, ST_NOISE, ST_SPAWN, ST_RD, ST_WR, ST_OUT
	} state_t;

	typedef enum logic [2:0] {JOB_SIZE, JOB_HUE, JOB_X, JOB_Y, JOB_VX, JOB_VY} job_t;

	function automatic logic signed [31:0] xmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p[47:16];
	endfunction

	function automatic logic [31:0] seed_mul(input logic [31:0] seed_raw);
		logic [31:0] s;
		s = seed_raw ^ SEED_MASK;
		if (s == 32'd0) s = 32'd1;
		return s * HASH_MUL1;
	endfunction

	localparam logic [31:0] SEED_MUL_RST = seed_mul(32'd0);
endpackage

// ----- design/cpt_if.sv -----
// Handshake channels of the cursor particle trail.
// Depends on nothing.
interface cpt_frame_if;
	logic valid;
	logic ready;
	logic signed [31:0] frame_dt;
	logic signed [31:0] frame_time;
	logic signed [31:0] pointer_x;
	logic signed [31:0] pointer_y;
	modport source(output valid, frame_dt, frame_time, pointer_x, pointer_y, input ready);
	modport sink(input valid, frame_dt, frame_time, pointer_x, pointer_y, output ready);
endinterface

interface cpt_result_if;
	logic valid;
	logic ready;
	logic [4:0] slot_index;
	logic updated;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [16:0] life_left;
	logic [19:0] dot_size;
	logic [24:0] dot_hue;
	logic last_slot;
	modport source(output valid, slot_index, updated, pos_x, pos_y, life_left, dot_size,
		dot_hue, last_slot, input ready);
	modport sink(input valid, slot_index, updated, pos_x, pos_y, life_left, dot_size,
		dot_hue, last_slot, output ready);
endinterface

interface cpt_cfg_if;
	logic valid;
	logic ready;
	logic [31:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- design/cursor_particle_trail.sv -----
// Cursor particle trail top level: frame sequencer, hashed noise pipeline and
// particle memory. Depends on cpt_pkg and the channel interfaces in cpt_if.sv.
//
// Usage: one frame item enters on frame (frame_dt, frame_time, pointer_x,
// pointer_y) and is accepted only while the block is idle. When the pointer
// moved far enough, one to three particles are spawned first: each takes four
// noise values (the first also size and hue), and every noise value passes
// through the four-stage hash pipeline before the next one is issued. All
// SLOTS slots are then walked: read from the synchronous memory, updated and,
// if live, written back, and presented on result, in the states RD, WR, OUT.
// last_slot marks the result of the final slot. While the receiver stalls
// the walk holds on the waiting result. Reset clears the live flags and spawn
// pointer and sets the previous pointer position and seed to their reset
// values; the rest of the memory is left as it is. cfg writes noise_seed
// between frames and is always ready; the user is to write it only between
// frames, as the block itself does not enforce this.
module cursor_particle_trail
	import cpt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	cpt_frame_if.sink frame,
	cpt_result_if.source result,
	cpt_cfg_if.sink cfg
);
	localparam int AW = $clog2(SLOTS);
	typedef struct packed {
		logic signed [31:0] x, y, vx, vy, life, size, hue;
	} part_t;

	part_t mem [SLOTS];
	part_t rd_s1;
	logic [SLOTS-1:0] alive_q;
	state_t st_q, st_d;
	job_t job_q;
	logic [31:0] smul_q;
	logic [AW-1:0] spawn_q, idx_q;
	logic [1:0] cnt_q, ncnt_q;
	logic signed [31:0] dt_q, tm_q, mx_q, my_q, dmx_q, dmy_q, px_q, py_q;
	logic signed [31:0] nsz_q, nhue_q, nx_q, ny_q, nvx_q, nvy_q;
	part_t upd_q;
	logic upd_live_q;

	logic nz_v_s1, nz_v_s2, nz_v_s3, nz_v_s4;
	logic [31:0] k0_s1, k1_s1, a0_s2, a1_s2;
	logic [15:0] frac_s1, frac_s2, frac_s3;
	logic signed [31:0] h0_s3, hd_s3, nz_s4;

	logic signed [31:0] dmx, dmy, ax, ay, mn, mxv, big, sml, speed;
	logic signed [31:0] ti, nz_pos, nz_cell;
	logic [31:0] nz_key0, nz_key1;
	part_t spw, nw;
	logic live;

	assign cfg.ready = 1'b1;
	assign frame.ready = (st_q == ST_IDLE);

	always_comb begin
		dmx = frame.pointer_x - px_q;
		dmy = frame.pointer_y - py_q;
		ax = dmx[31] ? -dmx : dmx;
		ay = dmy[31] ? -dmy : dmy;
		mn = (ax < ay) ? ax : ay;
		mxv = (ax > ay) ? ax : ay;
		big = $signed(mxv * AB_BIG) >>> 7;
		sml = $signed(mn * AB_SMALL) >>> 7;
		speed = big + sml;
	end

	always_comb begin
		ti = tm_q + {14'd0, cnt_q, 16'd0};
		case (job_q)
			JOB_SIZE: nz_pos = tm_q <<< 1;
			JOB_HUE: nz_pos = tm_q >>> 1;
			JOB_X: nz_pos = ti;
			JOB_Y: nz_pos = ti + K_OFF_Y;
			JOB_VX: nz_pos = ti + K_OFF_VX;
			JOB_VY: nz_pos = ti + K_OFF_VY;
			default: nz_pos = ti;
		endcase
		nz_cell = nz_pos >>> 16;
		nz_key0 = nz_cell ^ smul_q;
		nz_key1 = (nz_cell + 32'sd1) ^ smul_q;
	end

	always_comb begin
		spw.x = mx_q + xmul(nx_q - K_HALF, K_TEN);
		spw.y = my_q + xmul(ny_q - K_HALF, K_TEN);
		spw.vx = xmul(dmx_q, K_VSCALE) + xmul(nvx_q - K_HALF, K_TWO);
		spw.vy = xmul(dmy_q, K_VSCALE) + xmul(nvy_q - K_HALF, K_TWO);
		spw.life = K_ONE;
		spw.size = K_FOUR + xmul(nsz_q, K_FOUR);
		spw.hue = K_HUE0 + xmul(nhue_q, K_SIXTY);
	end

	always_comb begin
		live = alive_q[idx_q] && (rd_s1.life > 0);
		nw = rd_s1;
		nw.life = rd_s1.life - xmul(dt_q, K_LIFEDEC);
		if (nw.life < 0) nw.life = '0;
		nw.x = rd_s1.x + rd_s1.vx;
		nw.y = rd_s1.y + rd_s1.vy;
		nw.vx = xmul(rd_s1.vx, K_DAMP);
		nw.vy = xmul(rd_s1.vy, K_DAMP) + K_GRAV;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (frame.valid) st_d = (speed > K_THRESH) ? ST_ISSUE : ST_RD;
			ST_ISSUE: st_d = ST_NOISE;
			ST_NOISE: if (nz_v_s4) st_d = (job_q == JOB_VY) ? ST_SPAWN : ST_ISSUE;
			ST_SPAWN: st_d = (cnt_q + 2'd1 == ncnt_q) ? ST_RD : ST_ISSUE;
			ST_RD: st_d = ST_WR;
			ST_WR: st_d = ST_OUT;
			ST_OUT: if (result.ready)
				st_d = (idx_q == AW'(SLOTS - 1)) ? ST_IDLE : ST_RD;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			alive_q <= '0;
			spawn_q <= '0;
			smul_q <= SEED_MUL_RST;
			px_q <= K_PREV0;
			py_q <= K_PREV0;
			idx_q <= '0;
			cnt_q <= '0;
			ncnt_q <= '0;
			job_q <= JOB_SIZE;
		end else begin
			st_q <= st_d;
			if (cfg.valid) smul_q <= seed_mul(cfg.data);
			case (st_q)
				ST_IDLE: if (frame.valid) begin
					px_q <= frame.pointer_x;
					py_q <= frame.pointer_y;
					cnt_q <= '0;
					idx_q <= '0;
					job_q <= JOB_SIZE;
					if (speed > K_THRESH)
						ncnt_q <= (speed[31:19] >= 13'd2) ? 2'd3 : 2'(speed[19] + 2'd1);
					else
						ncnt_q <= '0;
				end
				ST_NOISE: if (nz_v_s4 && job_q != JOB_VY) job_q <= job_t'(job_q + 3'd1);
				ST_SPAWN: begin
					alive_q[spawn_q] <= 1'b1;
					spawn_q <= (spawn_q == AW'(SLOTS - 1)) ? '0 : spawn_q + AW'(1);
					cnt_q <= cnt_q + 2'd1;
					job_q <= JOB_X;
				end
				ST_WR: if (live && nw.life == 0) alive_q[idx_q] <= 1'b0;
				ST_OUT: if (result.ready) idx_q <= idx_q + AW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_v_s1 <= 1'b0;
			nz_v_s2 <= 1'b0;
			nz_v_s3 <= 1'b0;
			nz_v_s4 <= 1'b0;
		end else begin
			nz_v_s1 <= (st_q == ST_ISSUE);
			nz_v_s2 <= nz_v_s1;
			nz_v_s3 <= nz_v_s2;
			nz_v_s4 <= nz_v_s3;
		end
	end

	always_ff @(posedge clk) begin
		k0_s1 <= nz_key0 ^ (nz_key0 >> 16);
		k1_s1 <= nz_key1 ^ (nz_key1 >> 16);
		frac_s1 <= nz_pos[15:0];
		a0_s2 <= k0_s1 * HASH_MUL2;
		a1_s2 <= k1_s1 * HASH_MUL2;
		frac_s2 <= frac_s1;
		h0_s3 <= {16'd0, a0_s2[31:16]};
		hd_s3 <= {16'd0, a1_s2[31:16]} - {16'd0, a0_s2[31:16]};
		frac_s3 <= frac_s2;
		nz_s4 <= h0_s3 + xmul({16'd0, frac_s3}, hd_s3);
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && frame.valid) begin
			dt_q <= frame.frame_dt;
			tm_q <= frame.frame_time;
			mx_q <= frame.pointer_x;
			my_q <= frame.pointer_y;
			dmx_q <= dmx;
			dmy_q <= dmy;
		end
		if (st_q == ST_NOISE && nz_v_s4) begin
			case (job_q)
				JOB_SIZE: nsz_q <= nz_s4;
				JOB_HUE: nhue_q <= nz_s4;
				JOB_X: nx_q <= nz_s4;
				JOB_Y: ny_q <= nz_s4;
				JOB_VX: nvx_q <= nz_s4;
				JOB_VY: nvy_q <= nz_s4;
				default: ;
			endcase
		end
		if (st_q == ST_SPAWN) mem[spawn_q] <= spw;
		if (st_q == ST_WR && live) mem[idx_q] <= nw;
		rd_s1 <= mem[idx_q];
		if (st_q == ST_WR) begin
			upd_q <= nw;
			upd_live_q <= live;
		end
	end

	assign result.valid = (st_q == ST_OUT);
	assign result.slot_index = 5'(idx_q);
	assign result.updated = upd_live_q;
	assign result.pos_x = upd_live_q ? upd_q.x : '0;
	assign result.pos_y = upd_live_q ? upd_q.y : '0;
	assign result.life_left = upd_live_q ? upd_q.life[16:0] : '0;
	assign result.dot_size = upd_live_q ? upd_q.size[19:0] : '0;
	assign result.dot_hue = upd_live_q ? upd_q.hue[24:0] : '0;
	assign result.last_slot = (idx_q == AW'(SLOTS - 1));

	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !frame.ready) else $error("frame ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && $stable(idx_q)))
		else $error("result dropped");
	a_spawn_max: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SPAWN) |-> (cnt_q < ncnt_q)) else $error("spawn overrun");
endmodule
